// ===== hdl/two_way_sorted_merge_top_macros.svh =====
// ----------------------------------------------------------------------------
// Two-way sorted merge: assertion macros
// Clocked on clk, disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef TWO_WAY_SORTED_MERGE_TOP_MACROS_SVH
`define TWO_WAY_SORTED_MERGE_TOP_MACROS_SVH

`ifndef NO_ASSERTIONS

// Condition holds at every edge.
`define TSM_ASSERT(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// Same-cycle implication.
`define TSM_IMPLY(lbl, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error(msg);

// Next-cycle implication.
`define TSM_NEXT(lbl, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error(msg);

`else

`define TSM_ASSERT(lbl, cond, msg)
`define TSM_IMPLY(lbl, pre, post, msg)
`define TSM_NEXT(lbl, pre, post, msg)

`endif

`endif

// ===== hdl/tsm_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tsm_pkg
// Types and constants shared by the two-way sorted merge block.
// ----------------------------------------------------------------------------
package tsm_pkg;

	localparam int LIST_DEPTH = 32;
	localparam int DATA_WIDTH = 32;
	localparam int VALUE_W    = 32;
	localparam int CNT_W      = $clog2(LIST_DEPTH + 1);
	localparam int IDX_W      = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;

	localparam logic [1:0] OP_APPEND_A = 2'd0;
	localparam logic [1:0] OP_APPEND_B = 2'd1;
	localparam logic [1:0] OP_MERGE    = 2'd2;

	typedef logic signed [DATA_WIDTH-1:0] data_t;

	typedef struct packed {
		logic [1:0]                operation;
		logic signed [VALUE_W-1:0] value;
	} cmd_word_t;

	typedef struct packed {
		logic signed [VALUE_W-1:0] merged_value;
		logic                      last;
		logic                      empty_merge;
		logic                      overflow_seen;
	} res_word_t;

	// merge kickoff handed from the list front end to the sequencer
	typedef struct packed {
		logic             go;
		logic [CNT_W-1:0] cnt_a;
		logic [CNT_W-1:0] cnt_b;
		logic             ovf;
	} start_t;

	function automatic data_t to_data(input logic signed [VALUE_W-1:0] v);
		return DATA_WIDTH'(v);
	endfunction

	function automatic logic signed [VALUE_W-1:0] to_value(input data_t d);
		return VALUE_W'(d);
	endfunction

endpackage
`default_nettype wire

// ===== hdl/tsm_list_store.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tsm_list_store
// One list: single write port, one registered read port.
// ----------------------------------------------------------------------------
module tsm_list_store
	import tsm_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             wr_en,
	input  wire logic [IDX_W-1:0] wr_addr,
	input  wire data_t            wr_data,
	input  wire logic [IDX_W-1:0] rd_addr,
	output data_t                 rd_data
);

	data_t mem_q [LIST_DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		rd_data <= mem_q[rd_addr];
	end

endmodule
`default_nettype wire

// ===== hdl/tsm_merge_seq.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tsm_merge_seq
// Merge sequencer: one shared compare, output register, one word per cycle unless stalled.
// ----------------------------------------------------------------------------
`include "two_way_sorted_merge_top_macros.svh"

module tsm_merge_seq
	import tsm_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire start_t           start,
	input  wire data_t            a_data,
	input  wire data_t            b_data,
	output logic [IDX_W-1:0]      a_rd_addr,
	output logic [IDX_W-1:0]      b_rd_addr,
	output logic                  busy,
	output logic                  res_valid,
	input  wire logic             res_stall,
	output res_word_t             res
);

	typedef enum logic [1:0] {
		S_IDLE,
		S_PRIME,
		S_RUN
	} state_t;

	state_t           state_q;
	logic [CNT_W-1:0] ia_q, ib_q, cnt_a_q, cnt_b_q;
	logic             ovf_q;

	logic             have_a, have_b, take_a, empty_run, out_free, fire, last_nx;
	logic [CNT_W-1:0] ia_nx, ib_nx;
	data_t            pick;

	always_comb begin
		have_a    = ia_q < cnt_a_q;
		have_b    = ib_q < cnt_b_q;
		take_a    = have_a && (!have_b || (a_data < b_data));
		empty_run = (cnt_a_q == '0) && (cnt_b_q == '0);
		out_free  = !res_valid || !res_stall;
		fire      = (state_q == S_RUN) && out_free;
		ia_nx     = ia_q + CNT_W'(fire && !empty_run && take_a);
		ib_nx     = ib_q + CNT_W'(fire && !empty_run && !take_a);
		last_nx   = (ia_nx == cnt_a_q) && (ib_nx == cnt_b_q);
		pick      = empty_run ? '0 : (take_a ? a_data : b_data);
		a_rd_addr = ia_nx[IDX_W-1:0];
		b_rd_addr = ib_nx[IDX_W-1:0];
		busy      = state_q != S_IDLE;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			ia_q      <= '0;
			ib_q      <= '0;
			cnt_a_q   <= '0;
			cnt_b_q   <= '0;
			ovf_q     <= 1'b0;
			res_valid <= 1'b0;
		end else begin
			if (fire) begin
				res_valid <= 1'b1;
			end else if (!res_stall) begin
				res_valid <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (start.go) begin
						ia_q    <= '0;
						ib_q    <= '0;
						cnt_a_q <= start.cnt_a;
						cnt_b_q <= start.cnt_b;
						ovf_q   <= start.ovf;
						state_q <= S_PRIME;
					end
				end
				S_PRIME: begin
					state_q <= S_RUN;
				end
				S_RUN: begin
					ia_q <= ia_nx;
					ib_q <= ib_nx;
					if (fire && last_nx) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			res.merged_value  <= to_value(pick);
			res.last          <= last_nx;
			res.empty_merge   <= empty_run;
			res.overflow_seen <= ovf_q;
		end
	end

	`TSM_ASSERT(a_idx_in_range, (ia_q <= cnt_a_q) && (ib_q <= cnt_b_q), "merge index past list end")
	`TSM_IMPLY(a_start_idle, start.go, state_q == S_IDLE, "merge started while busy")
	`TSM_NEXT(a_last_ends_run, fire && last_nx, state_q == S_IDLE, "run did not end on last word")
	`TSM_IMPLY(a_empty_word, res_valid && res.empty_merge, res.last && (res.merged_value == '0), "bad empty-merge word")

endmodule
`default_nettype wire

// ===== hdl/two_way_sorted_merge_top.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// two_way_sorted_merge_top
// Two-list store with an ascending merge that streams the combined list.
// ----------------------------------------------------------------------------
// cmd channel (cmd_valid / cmd_stall / cmd): each word appends to list A or B,
// or merges; op code 3 is accepted and ignored. One append per cycle unless
// stalled; an append to a full list is dropped and sets a sticky overflow flag.
// res channel (res_valid / res_stall / res): a merge streams the merged
// ascending sequence, ties going to list B, last on the final word. Two empty
// lists give one zero word with empty_merge and last set. overflow_seen is the
// flag at merge start; the merge empties both lists and clears the flag.
// Timing: after a merge is accepted the sequencer primes the list reads in
// S_PRIME, then words follow one per cycle while res_stall is low, paced by the
// one compare unit and the registered list reads. cmd_stall is high while the
// sequencer is in S_PRIME or S_RUN, including while the receiver stalls.
// A stalled word holds in the output register and the sequencer waits; the
// next command is taken once the sequencer is done, even while the final word
// waits. Reset empties both lists, clears the flag and drops any pending word.
// ----------------------------------------------------------------------------
module two_way_sorted_merge_top
	import tsm_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      cmd_valid,
	output logic           cmd_stall,
	input  wire cmd_word_t cmd,
	output logic           res_valid,
	input  wire logic      res_stall,
	output res_word_t      res
);

	// list fill counts and sticky overflow flag
	logic [CNT_W-1:0] count_a_q, count_b_q;
	logic             ovf_q;

	logic             accept, is_a, is_b, full_a, full_b, wr_a, wr_b;
	logic             busy;
	data_t            wr_data, a_data, b_data;
	logic [IDX_W-1:0] a_rd_addr, b_rd_addr;
	start_t           start;

	// commands are held off only while the sequencer walks the lists
	assign cmd_stall = busy;
	assign accept    = cmd_valid && !cmd_stall;

	always_comb begin
		is_a        = cmd.operation == OP_APPEND_A;
		is_b        = cmd.operation == OP_APPEND_B;
		full_a      = count_a_q == CNT_W'(LIST_DEPTH);
		full_b      = count_b_q == CNT_W'(LIST_DEPTH);
		wr_a        = accept && is_a && !full_a;
		wr_b        = accept && is_b && !full_b;
		wr_data     = to_data(cmd.value);
		start.go    = accept && (cmd.operation == OP_MERGE);
		start.cnt_a = count_a_q;
		start.cnt_b = count_b_q;
		start.ovf   = ovf_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_a_q <= '0;
			count_b_q <= '0;
			ovf_q     <= 1'b0;
		end else if (start.go) begin
			// sequencer has latched counts and flag; lists are free again
			count_a_q <= '0;
			count_b_q <= '0;
			ovf_q     <= 1'b0;
		end else begin
			if (wr_a) begin
				count_a_q <= count_a_q + CNT_W'(1);
			end
			if (wr_b) begin
				count_b_q <= count_b_q + CNT_W'(1);
			end
			if ((accept && is_a && full_a) || (accept && is_b && full_b)) begin
				ovf_q <= 1'b1;
			end
		end
	end

	tsm_list_store u_list_a (
		.clk     (clk),
		.wr_en   (wr_a),
		.wr_addr (count_a_q[IDX_W-1:0]),
		.wr_data (wr_data),
		.rd_addr (a_rd_addr),
		.rd_data (a_data)
	);

	tsm_list_store u_list_b (
		.clk     (clk),
		.wr_en   (wr_b),
		.wr_addr (count_b_q[IDX_W-1:0]),
		.wr_data (wr_data),
		.rd_addr (b_rd_addr),
		.rd_data (b_data)
	);

	tsm_merge_seq u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.a_data    (a_data),
		.b_data    (b_data),
		.a_rd_addr (a_rd_addr),
		.b_rd_addr (b_rd_addr),
		.busy      (busy),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res       (res)
	);

endmodule
`default_nettype wire

// ===== bench/tsm_bench_pkg.sv =====
// ----------------------------------------------------------------------------
// Sorted merge scoreboard
// Tracks both lists and the sticky overflow flag as words are accepted. It
// queues the merged words that each merge command must produce and checks
// the result stream against that queue.
// ----------------------------------------------------------------------------
package tsm_bench_pkg;
	import tsm_pkg::*;

	// operation code with no meaning; the block must ignore it
	localparam logic [1:0] OP_IGNORED = 2'd3;

	class merge_scoreboard;
		data_t     list_a[$];
		data_t     list_b[$];
		bit        overflow;
		res_word_t merged_words_due[$];
		int        mismatches;
		int        merges;
		int        overflow_merges;
		int        empty_merges;
		int        checked;

		// accepted command word: update the lists, queue merge output
		function void note_command(cmd_word_t c);
			data_t     w;
			res_word_t r;
			int        ia;
			int        ib;
			int        total;
			bit        take_a;
			w = c.value[DATA_WIDTH-1:0];
			case (c.operation)
				OP_APPEND_A: begin
					if (list_a.size() < LIST_DEPTH) list_a = {list_a, w};
					else overflow = 1'b1;
				end
				OP_APPEND_B: begin
					if (list_b.size() < LIST_DEPTH) list_b = {list_b, w};
					else overflow = 1'b1;
				end
				OP_MERGE: begin
					merges++;
					if (overflow) overflow_merges++;
					total = list_a.size() + list_b.size();
					r.overflow_seen = overflow;
					if (total == 0) begin
						empty_merges++;
						r.merged_value = '0;
						r.last = 1'b1;
						r.empty_merge = 1'b1;
						merged_words_due = {merged_words_due, r};
					end else begin
						ia = 0;
						ib = 0;
						r.empty_merge = 1'b0;
						while (ia + ib < total) begin
							// A wins only when strictly smaller; ties go to B
							if (ia < list_a.size() && ib < list_b.size())
								take_a = list_a[ia] < list_b[ib];
							else
								take_a = ia < list_a.size();
							if (take_a) begin
								r.merged_value = list_a[ia];
								ia++;
							end else begin
								r.merged_value = list_b[ib];
								ib++;
							end
							r.last = (ia + ib == total);
							merged_words_due = {merged_words_due, r};
						end
					end
					list_a.delete();
					list_b.delete();
					overflow = 1'b0;
				end
				default: ;
			endcase
		endfunction

		function void check_result(res_word_t got);
			res_word_t exp;
			if (merged_words_due.size() == 0) begin
				$error("result word with nothing expected: merged_value %0d last %0b",
					got.merged_value, got.last);
				mismatches++;
				return;
			end
			exp = merged_words_due.pop_front();
			checked++;
			if (got.merged_value !== exp.merged_value) begin
				$error("merged_value: expected %0d, got %0d", exp.merged_value,
					got.merged_value);
				mismatches++;
			end
			if (got.last !== exp.last) begin
				$error("last: expected %0b, got %0b", exp.last, got.last);
				mismatches++;
			end
			if (got.empty_merge !== exp.empty_merge) begin
				$error("empty_merge: expected %0b, got %0b", exp.empty_merge,
					got.empty_merge);
				mismatches++;
			end
			if (got.overflow_seen !== exp.overflow_seen) begin
				$error("overflow_seen: expected %0b, got %0b", exp.overflow_seen,
					got.overflow_seen);
				mismatches++;
			end
		endfunction
	endclass

endpackage

// ===== bench/two_way_sorted_merge_top_test.sv =====
// ----------------------------------------------------------------------------
// Two-way sorted merge testbench
// Drives append and merge command words with random gaps, stalls the result
// channel at random, and checks every merged word against a scoreboard that
// tracks both lists. A directed opening covers the edge cases, then random
// append/merge sequences follow, some of them long enough to overflow.
// ----------------------------------------------------------------------------
module two_way_sorted_merge_top_test;
	import tsm_pkg::*;
	import tsm_bench_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int WORDS_TARGET = 500;
	// longest stretch without any word moving; real runs stay far below
	localparam int STALL_LIMIT  = 2000;
	// after the last expected word, give the block time to show strays
	localparam int TAIL_CYCLES  = 20;

	// value styles for random lists
	localparam int STY_FULL  = 0;
	localparam int STY_TIES  = 1;
	localparam int STY_EDGES = 2;

	logic      clk;
	logic      arst_n;
	logic      cmd_valid;
	logic      cmd_stall;
	cmd_word_t cmd;
	logic      res_valid;
	logic      res_stall;
	res_word_t res;

	merge_scoreboard sb = new();

	// both sides go gapless while calm is set
	bit calm;
	int words_sent;
	int idle_cycles;
	int rx_left;
	bit rx_hold;

	two_way_sorted_merge_top uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_stall (cmd_stall),
		.cmd       (cmd),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res       (res)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// mostly no gap, often a short one, now and then a long one
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	function automatic int rand_value(input int style);
		case (style)
			STY_TIES:  return int'($urandom_range(0, 8)) - 4;
			STY_EDGES: begin
				case ($urandom_range(0, 4))
					0:       return 32'sh8000_0000;
					1:       return 32'sh7FFF_FFFF;
					2:       return 0;
					3:       return -1;
					default: return $urandom;
				endcase
			end
			default:   return $urandom;
		endcase
	endfunction

	// Present one command word, hold it until taken, then log it.
	// valid stays high between back-to-back words (single NBA per step).
	task automatic send_word(input logic [1:0] op, input int v);
		int        gap;
		cmd_word_t w;
		gap = calm ? 0 : pick_gap();
		if (gap > 0) begin
			cmd_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		w.operation = op;
		w.value     = v;
		cmd       <= w;
		cmd_valid <= 1'b1;
		do @(posedge clk); while (cmd_stall);
		sb.note_command(w);
		words_sent++;
	endtask

	// Result side: check accepted words, then pick the next stall state.
	// Free runs alternate with stall bursts of random length.
	always @(posedge clk) begin
		if (arst_n) begin
			if (res_valid && !res_stall) sb.check_result(res);
			if (rx_left > 0) begin
				rx_left--;
			end else if (!rx_hold && !calm) begin
				rx_left = pick_gap();
				if (rx_left > 0) begin
					rx_hold = 1'b1;
					rx_left--;
				end
			end else begin
				rx_hold = 1'b0;
				rx_left = $urandom_range(0, 15);
			end
			res_stall <= rx_hold;
		end
	end

	// Watchdog: any accepted word on either side resets the count
	always @(posedge clk) begin
		if (arst_n) begin
			if ((cmd_valid && !cmd_stall) || (res_valid && !res_stall))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= STALL_LIMIT) begin
				$display("Timeout: no word moved for %0d cycles", STALL_LIMIT);
				$display("== FAIL ==");
				$finish;
			end
		end
	end

	initial begin : stimulus
		int qa[$];
		int qb[$];
		int na;
		int nb;
		int style;
		int kind;
		bit sorted;

		cmd_valid = 1'b0;
		cmd       = '0;
		res_stall = 1'b0;
		arst_n    = 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// ---- directed opening ----
		// merge of two empty lists: one zero word flagged empty
		send_word(OP_MERGE, 32'sh1234_5678);
		// signed extremes on both sides, with a tie at zero
		send_word(OP_APPEND_A, 32'sh7FFF_FFFF);
		send_word(OP_APPEND_A, 32'sh8000_0000);
		send_word(OP_APPEND_A, 0);
		send_word(OP_APPEND_B, 0);
		send_word(OP_APPEND_B, 32'sh8000_0000);
		send_word(OP_APPEND_B, -1);
		send_word(OP_APPEND_B, 32'sh7FFF_FFFF);
		// unused op code mid-sequence must change nothing
		send_word(OP_IGNORED, 32'shFFFF_FFFF);
		send_word(OP_MERGE, 0);
		// only A holds words: the rest of A is copied
		send_word(OP_APPEND_A, 7);
		send_word(OP_APPEND_A, 9);
		send_word(OP_MERGE, -1);
		// only B holds a word
		send_word(OP_APPEND_B, -3);
		send_word(OP_MERGE, 0);
		// equal heads: B goes first
		send_word(OP_APPEND_A, 5);
		send_word(OP_APPEND_B, 5);
		send_word(OP_IGNORED, 0);
		send_word(OP_MERGE, 0);

		// ---- random append/merge sequences ----
		while (words_sent < WORDS_TARGET) begin
			calm = ($urandom_range(0, 3) == 0);
			kind = $urandom_range(0, 9);
			if (kind == 0) begin
				// fill near or past the list depth to hit overflow
				na = $urandom_range(LIST_DEPTH - 4, LIST_DEPTH + 4);
				nb = $urandom_range(0, LIST_DEPTH + 4);
			end else begin
				na = $urandom_range(0, 8);
				nb = $urandom_range(0, 8);
			end
			style  = $urandom_range(STY_FULL, STY_EDGES);
			sorted = $urandom_range(0, 1);
			qa.delete();
			qb.delete();
			repeat (na) qa = {qa, rand_value(style)};
			repeat (nb) qb = {qb, rand_value(style)};
			if (sorted) begin
				qa.sort();
				qb.sort();
			end
			while (qa.size() != 0 || qb.size() != 0) begin
				if ($urandom_range(0, 19) == 0) send_word(OP_IGNORED, $urandom);
				if (qb.size() == 0 || (qa.size() != 0 && $urandom_range(0, 1)))
					send_word(OP_APPEND_A, qa.pop_front());
				else
					send_word(OP_APPEND_B, qb.pop_front());
			end
			// kind 1 leaves the lists loaded, so the next sequence piles on
			if (kind != 1) send_word(OP_MERGE, $urandom);
		end
		send_word(OP_MERGE, $urandom);
		cmd_valid <= 1'b0;
		calm = 1'b0;

		while (sb.merged_words_due.size() != 0) @(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("Sent %0d command words: %0d merges, %0d of them after overflow, %0d empty.",
			words_sent, sb.merges, sb.overflow_merges, sb.empty_merges);
		$display("Checked %0d merged words, %0d mismatches.", sb.checked, sb.mismatches);
		if (sb.mismatches == 0 && sb.merged_words_due.size() == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

// ===== sim.f =====
+incdir+hdl
hdl/tsm_pkg.sv
hdl/tsm_list_store.sv
hdl/tsm_merge_seq.sv
hdl/two_way_sorted_merge_top.sv
bench/tsm_bench_pkg.sv
bench/two_way_sorted_merge_top_test.sv
